### hw/rtl/tfl_pkg.sv
// ----------------------------------------------------------------------------
// tfl_pkg
// shared types, constants and the ntc ohm curve for the thermistor block
// ----------------------------------------------------------------------------
`default_nettype none
package tfl_pkg;
  localparam int CODE_W = 12;
  localparam int REG_W = 20;
  localparam int OHM_W = 24;
  localparam int TEMP_W = 16;
  localparam int CURVE_N = 176;
  localparam int CIDX_W = 8;
  localparam logic [OHM_W-1:0] OPEN_OHMS = 24'd10000000;
  localparam logic [CODE_W-1:0] PRESET_CODE = 12'd2048;
  localparam logic [1:0] ST_IN = 2'd0;
  localparam logic [1:0] ST_COLD = 2'd1;
  localparam logic [1:0] ST_HOT = 2'd2;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;      // capture input, write window
    logic sum_step;  // add one window entry
    logic div_init;  // set up the divider
    logic div_step;  // one quotient bit
    logic srch_init; // classify resistance, start search
    logic srch_step; // one binary search step
    logic frac_init; // set up fraction divide
    logic frac_step; // one fraction bit
    logic finish;    // build result word
  } tfl_cmd_t;

  typedef struct packed {
    logic sum_done;
    logic div_done;
    logic srch_done;
    logic frac_done;
  } tfl_sts_t;

  function automatic logic [OHM_W-1:0] ohm_curve(input logic [CIDX_W-1:0] i);
    logic [OHM_W-1:0] r;
    case (i)
      8'd0: r = 24'd6878030; 8'd1: r = 24'd6410610; 8'd2: r = 24'd5977290;
      8'd3: r = 24'd5575470; 8'd4: r = 24'd5202730; 8'd5: r = 24'd4856840;
      8'd6: r = 24'd4535760; 8'd7: r = 24'd4237610; 8'd8: r = 24'd3960650;
      8'd9: r = 24'd3703290; 8'd10: r = 24'd3464050; 8'd11: r = 24'd3241580;
      8'd12: r = 24'd3034620; 8'd13: r = 24'd2842020; 8'd14: r = 24'd2662720;
      8'd15: r = 24'd2495740; 8'd16: r = 24'd2340170; 8'd17: r = 24'd2195180;
      8'd18: r = 24'd2060000; 8'd19: r = 24'd1933920; 8'd20: r = 24'd1816280;
      8'd21: r = 24'd1706470; 8'd22: r = 24'd1603940; 8'd23: r = 24'd1508160;
      8'd24: r = 24'd1418660; 8'd25: r = 24'd1335000; 8'd26: r = 24'd1256750;
      8'd27: r = 24'd1183550; 8'd28: r = 24'd1115050; 8'd29: r = 24'd1050910;
      8'd30: r = 24'd990841; 8'd31: r = 24'd934558; 8'd32: r = 24'd881805;
      8'd33: r = 24'd832341; 8'd34: r = 24'd785945; 8'd35: r = 24'd742410;
      8'd36: r = 24'd701544; 8'd37: r = 24'd663170; 8'd38: r = 24'd627123;
      8'd39: r = 24'd593249; 8'd40: r = 24'd561406; 8'd41: r = 24'd531461;
      8'd42: r = 24'd503291; 8'd43: r = 24'd476781; 8'd44: r = 24'd451824;
      8'd45: r = 24'd428322; 8'd46: r = 24'd406182; 8'd47: r = 24'd385317;
      8'd48: r = 24'd365647; 8'd49: r = 24'd347098; 8'd50: r = 24'd329600;
      8'd51: r = 24'd313086; 8'd52: r = 24'd297498; 8'd53: r = 24'd282777;
      8'd54: r = 24'd268871; 8'd55: r = 24'd255731; 8'd56: r = 24'd243310;
      8'd57: r = 24'd231566; 8'd58: r = 24'd220456; 8'd59: r = 24'd209945;
      8'd60: r = 24'd200000; 8'd61: r = 24'd190577; 8'd62: r = 24'd181655;
      8'd63: r = 24'd173204; 8'd64: r = 24'd165194; 8'd65: r = 24'd157601;
      8'd66: r = 24'd150401; 8'd67: r = 24'd143572; 8'd68: r = 24'd137092;
      8'd69: r = 24'd130941; 8'd70: r = 24'd125102; 8'd71: r = 24'd119556;
      8'd72: r = 24'd114288; 8'd73: r = 24'd109282; 8'd74: r = 24'd104524;
      8'd75: r = 24'd100000; 8'd76: r = 24'd95697; 8'd77: r = 24'd91603;
      8'd78: r = 24'd87708; 8'd79: r = 24'd84000; 8'd80: r = 24'd80470;
      8'd81: r = 24'd77108; 8'd82: r = 24'd73905; 8'd83: r = 24'd70853;
      8'd84: r = 24'd67944; 8'd85: r = 24'd65171; 8'd86: r = 24'd62526;
      8'd87: r = 24'd60002; 8'd88: r = 24'd57595; 8'd89: r = 24'd55297;
      8'd90: r = 24'd53104; 8'd91: r = 24'd51010; 8'd92: r = 24'd49009;
      8'd93: r = 24'd47098; 8'd94: r = 24'd45272; 8'd95: r = 24'd43526;
      8'd96: r = 24'd41857; 8'd97: r = 24'd40261; 8'd98: r = 24'd38735;
      8'd99: r = 24'd37274; 8'd100: r = 24'd35880; 8'd101: r = 24'd34539;
      8'd102: r = 24'd33258; 8'd103: r = 24'd32031; 8'd104: r = 24'd30856;
      8'd105: r = 24'd29730; 8'd106: r = 24'd28652; 8'd107: r = 24'd27618;
      8'd108: r = 24'd26626; 8'd109: r = 24'd25676; 8'd110: r = 24'd24764;
      8'd111: r = 24'd23890; 8'd112: r = 24'd23051; 8'd113: r = 24'd22245;
      8'd114: r = 24'd21472; 8'd115: r = 24'd20730; 8'd116: r = 24'd20017;
      8'd117: r = 24'd19332; 8'd118: r = 24'd18674; 8'd119: r = 24'd18042;
      8'd120: r = 24'd17434; 8'd121: r = 24'd16850; 8'd122: r = 24'd16289;
      8'd123: r = 24'd15749; 8'd124: r = 24'd15229; 8'd125: r = 24'd14730;
      8'd126: r = 24'd14249; 8'd127: r = 24'd13786; 8'd128: r = 24'd13340;
      8'd129: r = 24'd12911; 8'd130: r = 24'd12498; 8'd131: r = 24'd12101;
      8'd132: r = 24'd11717; 8'd133: r = 24'd11348; 8'd134: r = 24'd10992;
      8'd135: r = 24'd10649; 8'd136: r = 24'd10319; 8'd137: r = 24'd10000;
      8'd138: r = 24'd9693; 8'd139: r = 24'd9396; 8'd140: r = 24'd9110;
      8'd141: r = 24'd8834; 8'd142: r = 24'd8568; 8'd143: r = 24'd8311;
      8'd144: r = 24'd8063; 8'd145: r = 24'd7824; 8'd146: r = 24'd7592;
      8'd147: r = 24'd7369; 8'd148: r = 24'd7153; 8'd149: r = 24'd6945;
      8'd150: r = 24'd6744; 8'd151: r = 24'd6549; 8'd152: r = 24'd6361;
      8'd153: r = 24'd6179; 8'd154: r = 24'd6003; 8'd155: r = 24'd5833;
      8'd156: r = 24'd5669; 8'd157: r = 24'd5510; 8'd158: r = 24'd5356;
      8'd159: r = 24'd5207; 8'd160: r = 24'd5063; 8'd161: r = 24'd4923;
      8'd162: r = 24'd4788; 8'd163: r = 24'd4658; 8'd164: r = 24'd4531;
      8'd165: r = 24'd4409; 8'd166: r = 24'd4290; 8'd167: r = 24'd4175;
      8'd168: r = 24'd4064; 8'd169: r = 24'd3956; 8'd170: r = 24'd3851;
      8'd171: r = 24'd3750; 8'd172: r = 24'd3651; 8'd173: r = 24'd3556;
      8'd174: r = 24'd3464; 8'd175: r = 24'd3374;
      default: r = 24'd3374;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

### hw/rtl/thermistor_filter_and_linearize.sv
// input word to result word runs a serial window sum over WINDOW entries,
// a 32-step resistance divide, up to 8 search steps and a 32-step fraction
// divide; one word at a time: the next input word is taken only after the
// result word has been accepted, so output stalls also hold off the input
// rst is synchronous: windows preset to 2048, pointers to 0, register 100000
// ----------------------------------------------------------------------------
// thermistor_filter_and_linearize
// averages converter samples per channel and converts them to ohms and q8 C
// ----------------------------------------------------------------------------
`default_nettype none
module thermistor_filter_and_linearize #(
  parameter int CHANNELS = 2,
  parameter int WINDOW = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [19:0] cfg_wdata,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // adc_sample[11:0]
  input  wire logic        s_axis_tuser,  // channel
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [55:0]      m_axis_tdata,  // filtered_code, resistance_ohms, temperature_q8
  output logic [2:0]       m_axis_tuser   // channel_out, range_status[1:0]
);
  import tfl_pkg::*;

  logic [REG_W-1:0] series_res;
  tfl_cmd_t cmd;
  tfl_sts_t sts;
  logic channel_out;
  logic [CODE_W-1:0] filtered_code;
  logic [OHM_W-1:0] resistance_ohms;
  logic [TEMP_W-1:0] temperature_q8;
  logic [1:0] range_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      series_res <= 20'd100000;
    end else if (cfg_we) begin
      series_res <= cfg_wdata;
    end
  end

  tfl_ctrl u_ctrl (
    .clk, .rst, .s_axis_tvalid, .s_axis_tready, .m_axis_tvalid, .m_axis_tready,
    .cmd, .sts
  );

  tfl_datapath #(.CHANNELS(CHANNELS), .WINDOW(WINDOW)) u_dp (
    .clk, .rst, .series_res,
    .in_channel(s_axis_tuser), .in_sample(s_axis_tdata[CODE_W-1:0]),
    .cmd, .sts, .channel_out, .filtered_code, .resistance_ohms,
    .temperature_q8, .range_status
  );

  assign m_axis_tdata = {4'd0, temperature_q8, resistance_ohms, filtered_code};
  assign m_axis_tuser = {range_status, channel_out};
endmodule
`default_nettype wire

### hw/rtl/tfl_ctrl.sv
// ----------------------------------------------------------------------------
// tfl_ctrl
// sequencer: window sum, resistance divide, table search, fraction divide
// ----------------------------------------------------------------------------
`default_nettype none
module tfl_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            s_axis_tvalid,
  output logic                 s_axis_tready,
  output logic                 m_axis_tvalid,
  input  wire logic            m_axis_tready,
  output tfl_pkg::tfl_cmd_t    cmd,
  input  wire tfl_pkg::tfl_sts_t sts
);
  import tfl_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SUM   = 4'd1;
  localparam logic [3:0] S_DINIT = 4'd2;
  localparam logic [3:0] S_DIV   = 4'd3;
  localparam logic [3:0] S_SINIT = 4'd4;
  localparam logic [3:0] S_SRCH  = 4'd5;
  localparam logic [3:0] S_FRAC  = 4'd6;
  localparam logic [3:0] S_FIN   = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  logic [3:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;
    case (state)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd.load = 1'b1;
          state_next = S_SUM;
        end
      end
      S_SUM: begin
        cmd.sum_step = 1'b1;
        if (sts.sum_done) begin
          state_next = S_DINIT;
        end
      end
      // mean is final only once the last window entry is in the sum
      S_DINIT: begin
        cmd.div_init = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) begin
          state_next = S_SINIT;
        end
      end
      S_SINIT: begin
        cmd.srch_init = 1'b1;
        state_next = S_SRCH;
      end
      S_SRCH: begin
        if (sts.srch_done) begin
          cmd.frac_init = 1'b1;
          state_next = S_FRAC;
        end else begin
          cmd.srch_step = 1'b1;
        end
      end
      S_FRAC: begin
        cmd.frac_step = 1'b1;
        if (sts.frac_done) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        m_axis_tvalid = 1'b1;
        if (m_axis_tready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

### hw/rtl/tfl_datapath.sv
// ----------------------------------------------------------------------------
// tfl_datapath
// sample windows, restoring dividers and binary search over the ohm curve
// ----------------------------------------------------------------------------
`default_nettype none
module tfl_datapath #(
  parameter int CHANNELS = 2,
  parameter int WINDOW = 8
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [tfl_pkg::REG_W-1:0]   series_res,
  input  wire logic                        in_channel,
  input  wire logic [tfl_pkg::CODE_W-1:0]  in_sample,
  input  wire tfl_pkg::tfl_cmd_t           cmd,
  output tfl_pkg::tfl_sts_t                sts,
  output logic                             channel_out,
  output logic [tfl_pkg::CODE_W-1:0]       filtered_code,
  output logic [tfl_pkg::OHM_W-1:0]        resistance_ohms,
  output logic [tfl_pkg::TEMP_W-1:0]       temperature_q8,
  output logic [1:0]                       range_status
);
  import tfl_pkg::*;

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int WP_W = $clog2(WINDOW);
  localparam int SUM_W = CODE_W + WP_W;
  localparam int PROD_W = REG_W + CODE_W;
  localparam int QB_W = $clog2(PROD_W + 1);
  localparam int FB_W = 5;

  logic [CODE_W-1:0] win [CHANNELS][WINDOW];
  logic [WP_W-1:0]   wptr [CHANNELS];
  logic [CH_W-1:0]   ch;
  logic [WP_W:0]     sidx;
  logic [SUM_W-1:0]  sum;
  logic [CODE_W-1:0] mean;

  // restoring divide of series*code by (span - code)
  logic [PROD_W-1:0] dnum;
  logic [CODE_W:0]   dden;
  logic [CODE_W+1:0] drem;
  logic [PROD_W-1:0] dquo;
  logic [QB_W-1:0]   dcnt;
  logic [OHM_W-1:0]  ohms;
  logic [CIDX_W-1:0] lo, hi, mid;
  logic [1:0]        rstat;
  logic              no_frac;
  logic [OHM_W-1:0]  fden;
  logic [OHM_W:0]    frem;
  logic [7:0]        fquo;
  logic [FB_W-1:0]   fcnt;
  logic [OHM_W-1:0]  fnum;
  logic [CODE_W+1:0] dtrial;
  logic [OHM_W:0]    ftrial;
  logic [OHM_W-1:0]  r_lo, r_hi;

  // the channel bit folds onto a single channel when only one exists
  logic [CH_W-1:0] ch_in;
  assign ch_in = (CHANNELS > 1) ? CH_W'(in_channel) : '0;

  assign mid = CIDX_W'((9'(lo) + 9'(hi)) >> 1);
  assign r_lo = ohm_curve(lo);
  assign r_hi = ohm_curve(hi);
  assign dtrial = {drem[CODE_W:0], dnum[PROD_W-1]};
  assign ftrial = {frem[OHM_W-1:0], fnum[OHM_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CHANNELS; c++) begin
        wptr[c] <= '0;
        for (int w = 0; w < WINDOW; w++) begin
          win[c][w] <= PRESET_CODE;
        end
      end
    end else if (cmd.load) begin
      win[ch_in][wptr[ch_in]] <= in_sample;
      wptr[ch_in] <= WP_W'((WP_W+1)'(wptr[ch_in]) + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ch <= ch_in;
      channel_out <= in_channel;
      sidx <= '0;
      sum <= '0;
    end
    if (cmd.sum_step) begin
      sum <= sum + SUM_W'(win[ch][sidx[WP_W-1:0]]);
      sidx <= sidx + 1'b1;
    end
    if (cmd.div_init) begin
      dnum <= PROD_W'(series_res) * PROD_W'(mean);
      dden <= (CODE_W+1)'(1 << CODE_W) - (CODE_W+1)'(mean);
      drem <= '0;
      dquo <= '0;
      dcnt <= '0;
    end
    if (cmd.div_step) begin
      dnum <= dnum << 1;
      dcnt <= dcnt + 1'b1;
      if (dtrial >= (CODE_W+2)'(dden)) begin
        drem <= dtrial - (CODE_W+2)'(dden);
        dquo <= {dquo[PROD_W-2:0], 1'b1};
      end else begin
        drem <= dtrial;
        dquo <= {dquo[PROD_W-2:0], 1'b0};
      end
    end
    if (cmd.srch_init) begin
      lo <= '0;
      hi <= CIDX_W'(CURVE_N - 1);
      if (ohms >= ohm_curve('0)) begin
        rstat <= ST_COLD;
      end else if (ohms <= ohm_curve(CIDX_W'(CURVE_N - 1))) begin
        rstat <= ST_HOT;
      end else begin
        rstat <= ST_IN;
      end
    end
    if (cmd.srch_step) begin
      if (ohm_curve(mid) >= ohms) begin
        lo <= mid;
      end else begin
        hi <= mid;
      end
    end
    if (cmd.frac_init) begin
      fnum <= r_lo - ohms;
      fden <= r_lo - r_hi;
      no_frac <= !(r_lo > r_hi);
      frem <= '0;
      fquo <= '0;
      fcnt <= '0;
    end
    if (cmd.frac_step) begin
      fcnt <= fcnt + 1'b1;
      // numerator is fnum * 256: feed fnum bits, then eight zeros
      fnum <= fnum << 1;
      if (ftrial >= (OHM_W+1)'(fden)) begin
        frem <= ftrial - (OHM_W+1)'(fden);
        fquo <= {fquo[6:0], 1'b1};
      end else begin
        frem <= ftrial;
        fquo <= {fquo[6:0], 1'b0};
      end
    end
    if (cmd.finish) begin
      filtered_code <= mean;
      resistance_ohms <= ohms;
      range_status <= rstat;
      case (rstat)
        ST_COLD: temperature_q8 <= TEMP_W'(-12800);
        ST_HOT:  temperature_q8 <= TEMP_W'((CURVE_N - 51) * 256);
        default: temperature_q8 <= TEMP_W'((17'(lo) << 8) - 17'd12800)
                                   + TEMP_W'(no_frac ? 8'd0 : fquo);
      endcase
    end
  end

  assign mean = CODE_W'(sum >> WP_W);

  always_comb begin
    if (mean == '0) begin
      ohms = OPEN_OHMS;
    end else if (dquo > PROD_W'(OPEN_OHMS)) begin
      ohms = OPEN_OHMS;
    end else begin
      ohms = OHM_W'(dquo);
    end
  end

  assign sts.sum_done  = (sidx == (WP_W+1)'(WINDOW - 1)) && cmd.sum_step;
  assign sts.div_done  = (dcnt == QB_W'(PROD_W - 1));
  assign sts.srch_done = (rstat != ST_IN) || (9'(hi) - 9'(lo) <= 9'd1);
  assign sts.frac_done = (fcnt == FB_W'(OHM_W + 8 - 1)) || no_frac;
endmodule
`default_nettype wire

### hw/rtl/tfl_checker.sv
// ----------------------------------------------------------------------------
// tfl_checker
// port-level checks of the thermistor block
// ----------------------------------------------------------------------------
`default_nettype none
module tfl_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [55:0] m_axis_tdata,
  input wire logic [2:0]  m_axis_tuser
);
  // one word in flight: never ready for input while a result waits
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid)) else $error("ready while result pending");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped");
  a_stat: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tuser[2:1] != 2'd3) else $error("bad status");
  a_lat: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid) else $error("early result");
endmodule

bind thermistor_filter_and_linearize tfl_checker u_chk (
  .clk, .rst, .s_axis_tvalid, .s_axis_tready, .m_axis_tvalid, .m_axis_tready,
  .m_axis_tdata, .m_axis_tuser
);
`default_nettype wire

### dv/thermistor_filter_and_linearize_test.sv
// ----------------------------------------------------------------------------
// thermistor_filter_and_linearize_test
// drives channel samples under random stalls, predicts window mean, ohms and
// q8 temperature per word, and compares every output word in order
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module thermistor_filter_and_linearize_test;
  import tfl_pkg::*;

  typedef struct {
    logic              chan;
    logic [CODE_W-1:0] code;
    logic [OHM_W-1:0]  ohms;
    logic [TEMP_W-1:0] temp;
    logic [1:0]        status;
  } reading_t;

  // unpacked table copy kept local so the board class needs no package function
  int unsigned ohm_table [CURVE_N];

  class reading_board;
    logic [CODE_W-1:0] window_mem [2][8];
    int unsigned       wr_ptr [2];
    int unsigned       series_ohms;
    reading_t          pending [$];
    int                errors;

    function void clear();
      for (int c = 0; c < 2; c++) begin
        wr_ptr[c] = 0;
        for (int i = 0; i < 8; i++) window_mem[c][i] = PRESET_CODE;
      end
      series_ohms = 100000;
      pending.delete();
      errors = 0;
    endfunction

    function int unsigned curve_at(int i);
      return ohm_table[i];
    endfunction

    function void note_sample(logic chan, logic [CODE_W-1:0] sample);
      reading_t r;
      int unsigned sum, mean, lo, hi, mid, frac;
      longint unsigned q;
      sum = 0;
      window_mem[chan][wr_ptr[chan]] = sample;
      wr_ptr[chan] = (wr_ptr[chan] + 1) % 8;
      for (int i = 0; i < 8; i++) sum += window_mem[chan][i];
      mean = sum / 8;
      r.chan = chan;
      r.code = mean[CODE_W-1:0];
      if (mean == 0) q = 10000000;
      else begin
        q = (longint'(series_ohms) * mean) / (4096 - mean);
        if (q > 10000000) q = 10000000;
      end
      r.ohms = q[OHM_W-1:0];
      if (q >= curve_at(0)) begin
        r.status = ST_COLD;
        r.temp = -16'sd12800;
      end else if (q <= curve_at(CURVE_N-1)) begin
        r.status = ST_HOT;
        r.temp = 16'sd32000;
      end else begin
        lo = 0;
        hi = CURVE_N - 1;
        while (hi - lo > 1) begin
          mid = (lo + hi) / 2;
          if (curve_at(mid) >= q) lo = mid;
          else hi = mid;
        end
        frac = 0;
        if (curve_at(lo) > curve_at(hi))
          frac = 32'(((curve_at(lo) - q) * 256) / (curve_at(lo) - curve_at(hi)));
        if (frac > 255) frac = 255;
        r.status = ST_IN;
        r.temp = 16'((int'(lo) - 50) * 256 + int'(frac));
      end
      pending.push_back(r);
    endfunction

    function void report(string what, longint got, longint want);
      $display("mismatch %s: got %0d want %0d", what, got, want);
      errors++;
    endfunction

    function void check_word(logic [55:0] data, logic [2:0] user);
      reading_t e;
      if (pending.size() == 0) begin
        report("unexpected word", data, 0);
        return;
      end
      e = pending.pop_front();
      if (user[0] !== e.chan) report("channel", user[0], e.chan);
      if (user[2:1] !== e.status) report("range status", user[2:1], e.status);
      if (data[11:0] !== e.code) report("filtered code", data[11:0], e.code);
      if (data[35:12] !== e.ohms) report("resistance", data[35:12], e.ohms);
      if (data[51:36] !== e.temp)
        report("temperature", $signed(data[51:36]), $signed(e.temp));
      if (data[55:52] !== 4'd0) report("pad", data[55:52], 0);
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_we = 0;
  logic [19:0] cfg_wdata = 0;
  logic        s_axis_tvalid = 0;
  wire         s_axis_tready;
  logic [15:0] s_axis_tdata = 0;  // adc_sample[11:0]
  logic        s_axis_tuser = 0;  // channel
  wire         m_axis_tvalid;
  logic        m_axis_tready = 0;
  wire  [55:0] m_axis_tdata;  // filtered_code, resistance_ohms, temperature_q8
  wire  [2:0]  m_axis_tuser;  // channel_out, range_status[1:0]

  reading_board board = new();
  int           cycles = 0;
  bit           quiet = 0;
  bit           hold_long = 0;
  int           rx_idle = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  thermistor_filter_and_linearize u_top (
    .clk, .rst, .cfg_we, .cfg_wdata,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 1500000) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      board.check_word(m_axis_tdata, m_axis_tuser);
    end
  end

  // receiver: random idle bursts, one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 0;
      rx_idle <= 0;
    end else if (hold_long) m_axis_tready <= 0;
    else if (quiet) m_axis_tready <= 1;
    else if (rx_idle > 0) begin
      m_axis_tready <= 0;
      rx_idle <= rx_idle - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      m_axis_tready <= 0;
      rx_idle <= $urandom_range(0, 9);
    end else m_axis_tready <= 1;
  end

  initial begin
    int stall;
    @(posedge clk);
    forever begin
      wait (hold_long);
      stall = 0;
      while (stall < 600) begin
        @(posedge clk);
        stall++;
      end
      hold_long = 0;
    end
  end

  task automatic send_sample(logic chan, logic [11:0] sample);
    int gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 10);
      s_axis_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser <= chan;
    s_axis_tdata <= {4'b0, sample};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    board.note_sample(chan, sample);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    s_axis_tvalid <= 0;
    while (board.pending.size() > 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (100) @(posedge clk);
  endtask

  task automatic set_series(int unsigned ohms);
    cfg_we <= 1;
    cfg_wdata <= ohms[19:0];
    @(posedge clk);
    cfg_we <= 0;
    board.series_ohms = ohms & 32'hFFFFF;
  endtask

  task automatic random_phase(int n);
    logic [11:0] s;
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(0, 5))
        0: s = 12'($urandom_range(0, 4095));
        1: s = 12'($urandom_range(0, 8));
        2: s = 12'($urandom_range(4087, 4095));
        default: s = 12'($urandom_range(800, 3600));
      endcase
      send_sample(1'($urandom_range(0, 1)), s);
    end
  endtask

  initial begin
    int unsigned settings [6];
    for (int i = 0; i < CURVE_N; i++) ohm_table[i] = ohm_curve(8'(i));
    board.clear();
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: extremes, warm-up, both channels, open and short
    send_sample(0, 12'd0);
    send_sample(1, 12'd4095);
    for (int i = 0; i < 8; i++) send_sample(0, 12'd0);
    for (int i = 0; i < 8; i++) send_sample(1, 12'd4095);
    send_sample(0, 12'hAAA);
    send_sample(1, 12'h555);
    drain();

    settings = '{100000, 1000, 1000000, 1048575, 0, 10000};
    for (int p = 0; p < 6; p++) begin
      set_series(settings[p]);
      if (p == 2) hold_long = 1;
      if (p == 5) quiet = 1;
      random_phase(p == 0 ? 400 : 200);
      drain();
    end

    if (board.pending.size() == 0 && board.errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule
`default_nettype wire

### files.f
hw/rtl/tfl_pkg.sv
hw/rtl/tfl_ctrl.sv
hw/rtl/tfl_datapath.sv
hw/rtl/thermistor_filter_and_linearize.sv
hw/rtl/tfl_checker.sv
dv/thermistor_filter_and_linearize_test.sv
